// ===== hw/rtl/c8x_pkg.sv =====
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types, opcode group codes and stream field offsets for the CHIP-8
// instruction execute block.
// ----------------------------------------------------------------------------
package c8x_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SLW         = $clog2(STACK_DEPTH + 1);
  localparam int SIW         = $clog2(STACK_DEPTH);
  localparam int NUM_REGS    = 16;

  typedef logic [11:0] addr_t;
  typedef logic [7:0]  byte_t;
  typedef logic [3:0]  ridx_t;

  localparam addr_t START_ADDRESS = 12'd512;
  localparam ridx_t FLAG_REG      = 4'hF;
  localparam ridx_t ZERO_REG      = 4'h0;

  localparam logic [15:0] OP_RET  = 16'h00EE;
  localparam byte_t       KK_SKP  = 8'h9E;
  localparam byte_t       KK_SKNP = 8'hA1;

  // opcode groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV0 = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_KEY  = 4'hE;

  // 8xyN operations
  localparam logic [3:0] ALU_LD   = 4'h0;
  localparam logic [3:0] ALU_OR   = 4'h1;
  localparam logic [3:0] ALU_AND  = 4'h2;
  localparam logic [3:0] ALU_XOR  = 4'h3;
  localparam logic [3:0] ALU_ADD  = 4'h4;
  localparam logic [3:0] ALU_SUB  = 4'h5;
  localparam logic [3:0] ALU_SHR  = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL  = 4'hE;

  // input stream layout
  localparam int IN_W = 40;
  // output stream layout, lowest bit up
  localparam int OUT_W      = 48;
  localparam int O_NPC      = 0;
  localparam int O_RW       = 12;
  localparam int O_RIDX     = 13;
  localparam int O_RVAL     = 17;
  localparam int O_FW       = 25;
  localparam int O_FVAL     = 26;
  localparam int O_IDX      = 27;
  localparam int O_FAULT    = 39;
  localparam int O_UNH      = 40;
  localparam int O_USED     = 41;

  typedef struct packed {
    addr_t next_pc;
    logic  reg_write;
    ridx_t reg_index;
    byte_t reg_value;
    logic  flag_write;
    logic  flag_value;
    addr_t index_value;
    logic  stack_fault;
    logic  unhandled;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  typedef struct packed {
    logic  en;
    ridx_t idx;
    byte_t val;
    logic  fl_en;
    logic  fl_val;
  } wr_port_t;

endpackage

// ===== hw/rtl/c8x_regfile.sv =====
// ----------------------------------------------------------------------------
// c8x_regfile
// V0..VE in a two-read, one-write array with registered reads, write-through
// bypass and per-entry valid bits; VF kept as its own register.
// ----------------------------------------------------------------------------
module c8x_regfile
  import c8x_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     rd_en_i,
  input  ridx_t    ra_i,
  input  ridx_t    rb_i,
  input  wr_port_t wr_i,
  output byte_t    va_o,
  output byte_t    vb_o
);

  byte_t               mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] vld_q, vld_d;
  byte_t               vf_q, vf_d;
  byte_t               rda_q, rdb_q;
  ridx_t               ra_q, rb_q;
  logic                mem_we;

  assign mem_we = wr_i.en && (wr_i.idx != FLAG_REG);

  always_comb begin
    vld_d = vld_q;
    if (mem_we) begin
      vld_d[wr_i.idx] = 1'b1;
    end
  end

  // result write wins over the flag when x is VF
  always_comb begin
    vf_d = vf_q;
    if (wr_i.en && (wr_i.idx == FLAG_REG)) begin
      vf_d = wr_i.val;
    end else if (wr_i.fl_en) begin
      vf_d = {7'd0, wr_i.fl_val};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      vf_q  <= '0;
    end else begin
      vld_q <= vld_d;
      vf_q  <= vf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_i.idx] <= wr_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ra_q <= ra_i;
      rb_q <= rb_i;
      if (mem_we && (wr_i.idx == ra_i)) begin
        rda_q <= wr_i.val;
      end else begin
        rda_q <= vld_q[ra_i] ? mem_q[ra_i] : '0;
      end
      if (mem_we && (wr_i.idx == rb_i)) begin
        rdb_q <= wr_i.val;
      end else begin
        rdb_q <= vld_q[rb_i] ? mem_q[rb_i] : '0;
      end
    end
  end

  assign va_o = (ra_q == FLAG_REG) ? vf_q : rda_q;
  assign vb_o = (rb_q == FLAG_REG) ? vf_q : rdb_q;

endmodule

// ===== hw/rtl/c8x_exec.sv =====
// ----------------------------------------------------------------------------
// c8x_exec
// Decode and execute of one instruction: compares, 8-bit ALU, branch target
// and stack control.
// ----------------------------------------------------------------------------
module c8x_exec
  import c8x_pkg::*;
(
  input  logic [15:0] instr_i,
  input  logic [15:0] key_mask_i,
  input  byte_t       rand_byte_i,
  input  byte_t       vx_i,
  input  byte_t       vy_i,
  input  addr_t       pc_i,
  input  addr_t       index_i,
  input  logic        stack_empty_i,
  input  logic        stack_full_i,
  input  addr_t       stack_top_i,
  output result_t     res_o,
  output stack_ctl_t  ctl_o
);

  logic [3:0] grp, n;
  ridx_t      x;
  byte_t      kk;
  addr_t      nnn, pc2, pc4;
  logic [8:0] sum;
  logic       key_bit;
  result_t    r;
  stack_ctl_t c;

  assign grp     = instr_i[15:12];
  assign x       = instr_i[11:8];
  assign n       = instr_i[3:0];
  assign kk      = instr_i[7:0];
  assign nnn     = instr_i[11:0];
  assign pc2     = pc_i + 12'd2;
  assign pc4     = pc_i + 12'd4;
  assign sum     = {1'b0, vx_i} + {1'b0, vy_i};
  assign key_bit = key_mask_i[vx_i[3:0]];

  always_comb begin
    r             = '0;
    c             = '0;
    r.next_pc     = pc2;
    r.index_value = index_i;
    unique case (grp)
      GRP_SYS: begin
        if (instr_i == OP_RET) begin
          if (stack_empty_i) begin
            r.stack_fault = 1'b1;
            r.next_pc     = pc_i;
          end else begin
            c.pop     = 1'b1;
            r.next_pc = stack_top_i;
          end
        end else begin
          r.unhandled = 1'b1;
        end
      end
      GRP_JP: r.next_pc = nnn;
      GRP_CALL: begin
        if (stack_full_i) begin
          r.stack_fault = 1'b1;
          r.next_pc     = pc_i;
        end else begin
          c.push    = 1'b1;
          r.next_pc = nnn;
        end
      end
      GRP_SE: begin
        if (vx_i == kk) r.next_pc = pc4;
      end
      GRP_SNE: begin
        if (vx_i != kk) r.next_pc = pc4;
      end
      GRP_SER: begin
        if (n != 4'd0) begin
          r.unhandled = 1'b1;
        end else if (vx_i == vy_i) begin
          r.next_pc = pc4;
        end
      end
      GRP_LD: begin
        r.reg_write = 1'b1;
        r.reg_value = kk;
      end
      GRP_ADD: begin
        r.reg_write = 1'b1;
        r.reg_value = vx_i + kk;
      end
      GRP_ALU: begin
        unique case (n)
          ALU_LD: begin
            r.reg_write = 1'b1;
            r.reg_value = vy_i;
          end
          ALU_OR: begin
            r.reg_write = 1'b1;
            r.reg_value = vx_i | vy_i;
          end
          ALU_AND: begin
            r.reg_write = 1'b1;
            r.reg_value = vx_i & vy_i;
          end
          ALU_XOR: begin
            r.reg_write = 1'b1;
            r.reg_value = vx_i ^ vy_i;
          end
          ALU_ADD: begin
            r.reg_write  = 1'b1;
            r.flag_write = 1'b1;
            r.flag_value = sum[8];
            r.reg_value  = sum[7:0];
          end
          ALU_SUB: begin
            r.reg_write  = 1'b1;
            r.flag_write = 1'b1;
            r.flag_value = (vx_i >= vy_i);
            r.reg_value  = vx_i - vy_i;
          end
          ALU_SHR: begin
            r.reg_write  = 1'b1;
            r.flag_write = 1'b1;
            r.flag_value = vx_i[0];
            r.reg_value  = {1'b0, vx_i[7:1]};
          end
          ALU_SUBN: begin
            r.reg_write  = 1'b1;
            r.flag_write = 1'b1;
            r.flag_value = (vy_i >= vx_i);
            r.reg_value  = vy_i - vx_i;
          end
          ALU_SHL: begin
            r.reg_write  = 1'b1;
            r.flag_write = 1'b1;
            r.flag_value = vx_i[7];
            r.reg_value  = {vx_i[6:0], 1'b0};
          end
          default: r.unhandled = 1'b1;
        endcase
      end
      GRP_SNER: begin
        if (n != 4'd0) begin
          r.unhandled = 1'b1;
        end else if (vx_i != vy_i) begin
          r.next_pc = pc4;
        end
      end
      GRP_LDI:  r.index_value = nnn;
      // vy carries V0 for this group
      GRP_JPV0: r.next_pc = nnn + {4'd0, vy_i};
      GRP_RND: begin
        r.reg_write = 1'b1;
        r.reg_value = rand_byte_i & kk;
      end
      GRP_KEY: begin
        if (kk == KK_SKP) begin
          if (key_bit) r.next_pc = pc4;
        end else if (kk == KK_SKNP) begin
          if (!key_bit) r.next_pc = pc4;
        end else begin
          r.unhandled = 1'b1;
        end
      end
      default: r.unhandled = 1'b1;
    endcase
    r.reg_index = r.reg_write ? x : '0;
  end

  assign res_o = r;
  assign ctl_o = c;

endmodule

// ===== hw/rtl/chip8_instruction_execute.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute
// Executes one CHIP-8 instruction per request against V0..VF, PC, I and the
// return stack, and returns the architectural effects of each.
//
//   port    dir  width  contents (low bit up)
//   s_axis  in   40     instruction[15:0] key_mask[31:16] rand_byte[39:32]
//   m_axis  out  48     next_pc, reg_write, reg_index, reg_value, flag_write,
//                       flag_value, index_value, stack_fault, unhandled, pad
//
// One request per cycle unless m_axis stalls; m_axis valid is registered
// (register read at accept, then decode/ALU into the output register).
// Register writes bypass into a request read in the same cycle.
// Reset: PC = 0x200, I = 0, V0..VF = 0, stack empty; no clearing pass.
// A stalled m_axis holds its result and the request behind it in place.
// ----------------------------------------------------------------------------
module chip8_instruction_execute
  import c8x_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,   // instruction, key_mask, rand_byte
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [OUT_W-1:0] m_axis_tdata    // next_pc .. unhandled, zero pad
);

  logic             in_vld_q;
  logic [15:0]      instr_q, keys_q;
  byte_t            rnd_q;
  addr_t            pc_q, idx_q;
  logic [SLW-1:0]   lvl_q, lvl_d, lvl_m1, lvl_m2;
  addr_t            stack_q [STACK_DEPTH];
  addr_t            top_q;
  logic             out_vld_q;
  logic [OUT_W-1:0] out_q;

  logic       exec_go, in_go;
  ridx_t      ra, rb;
  byte_t      vx, vy;
  wr_port_t   wr;
  result_t    res;
  stack_ctl_t sctl;
  logic       stk_empty, stk_full;
  addr_t      stk_top;

  assign exec_go       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || exec_go;
  assign in_go         = s_axis_tvalid && s_axis_tready;

  assign ra = s_axis_tdata[11:8];
  assign rb = (s_axis_tdata[15:12] == GRP_JPV0) ? ZERO_REG : s_axis_tdata[7:4];

  assign wr.en     = exec_go && res.reg_write;
  assign wr.idx    = res.reg_index;
  assign wr.val    = res.reg_value;
  assign wr.fl_en  = exec_go && res.flag_write;
  assign wr.fl_val = res.flag_value;

  c8x_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_go),
    .ra_i    (ra),
    .rb_i    (rb),
    .wr_i    (wr),
    .va_o    (vx),
    .vb_o    (vy)
  );

  assign lvl_m1    = lvl_q - SLW'(1);
  assign lvl_m2    = lvl_q - SLW'(2);
  assign stk_empty = (lvl_q == '0);
  assign stk_full  = (lvl_q == SLW'(STACK_DEPTH));
  assign stk_top   = top_q;

  c8x_exec u_exec (
    .instr_i       (instr_q),
    .key_mask_i    (keys_q),
    .rand_byte_i   (rnd_q),
    .vx_i          (vx),
    .vy_i          (vy),
    .pc_i          (pc_q),
    .index_i       (idx_q),
    .stack_empty_i (stk_empty),
    .stack_full_i  (stk_full),
    .stack_top_i   (stk_top),
    .res_o         (res),
    .ctl_o         (sctl)
  );

  always_comb begin
    lvl_d = lvl_q;
    if (sctl.push) begin
      lvl_d = lvl_q + SLW'(1);
    end else if (sctl.pop) begin
      lvl_d = lvl_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= START_ADDRESS;
      idx_q     <= '0;
      lvl_q     <= '0;
    end else begin
      if (in_go) begin
        in_vld_q <= 1'b1;
      end else if (exec_go) begin
        in_vld_q <= 1'b0;
      end
      if (exec_go) begin
        out_vld_q <= 1'b1;
        pc_q      <= res.next_pc;
        idx_q     <= res.index_value;
        lvl_q     <= lvl_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_go) begin
      instr_q <= s_axis_tdata[15:0];
      keys_q  <= s_axis_tdata[31:16];
      rnd_q   <= s_axis_tdata[39:32];
    end
  end

  // top of stack kept in its own register; a pop refills it from below
  always_ff @(posedge clk_i) begin
    if (exec_go && sctl.push) begin
      stack_q[lvl_q[SIW-1:0]] <= pc_q + 12'd2;
      top_q                   <= pc_q + 12'd2;
    end else if (exec_go && sctl.pop) begin
      top_q <= stack_q[lvl_m2[SIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      out_q <= {(OUT_W-O_USED)'(0), res.unhandled, res.stack_fault, res.index_value,
                res.flag_value, res.flag_write, res.reg_value, res.reg_index,
                res.reg_write, res.next_pc};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== hw/rtl/c8x_checker.sv =====
// ----------------------------------------------------------------------------
// c8x_checker
// Port-level checks on the execute block's result stream.
// ----------------------------------------------------------------------------
module c8x_checker
  import c8x_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[O_RW] |->
      (m_axis_tdata[O_RVAL-1:O_RIDX] == '0) && (m_axis_tdata[O_FW-1:O_RVAL] == '0))
    else $error("register fields set without a write");

  a_fault_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[O_FAULT] || m_axis_tdata[O_UNH]) |->
      !m_axis_tdata[O_RW] && !m_axis_tdata[O_FW])
    else $error("faulted request wrote a register");

  a_flag_with_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[O_FW] |-> m_axis_tdata[O_RW] && !m_axis_tdata[O_UNH])
    else $error("flag write without register write");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request side blocked without a stalled result");

endmodule

bind chip8_instruction_execute c8x_checker u_c8x_checker (.*);

// ===== test/chip8_instruction_execute_test.sv =====
// ----------------------------------------------------------------------------
// chip8_instruction_execute_test
// Runs CHIP-8 instruction streams through the execute block and checks the
// reported effects of each request against a shadow copy of V0..VF, PC, I and
// the return stack. Covers a short directed list, then biased random programs
// with stack overflow/underflow bursts and random stalls on both streams.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_test;
  timeunit 1ns;
  timeprecision 1ps;

  import c8x_pkg::*;

  localparam int RANDOM_REQUESTS = 780;

  class chip8_shadow;
    byte_t       vreg [NUM_REGS];
    addr_t       pc;
    addr_t       ireg;
    addr_t       ret_stack [STACK_DEPTH];
    int unsigned level;
    result_t     effects_q [$];
    int unsigned failures;

    function new();
      foreach (vreg[i]) vreg[i] = '0;
      foreach (ret_stack[i]) ret_stack[i] = '0;
      pc       = START_ADDRESS;
      ireg     = '0;
      level    = 0;
      failures = 0;
    endfunction

    function int unsigned pending();
      return effects_q.size();
    endfunction

    // execute one accepted request and queue its effects
    function void retire(logic [15:0] op, logic [15:0] keys, byte_t rnd);
      result_t    r;
      ridx_t      x;
      ridx_t      y;
      logic [3:0] n;
      byte_t      kk;
      byte_t      vx;
      byte_t      vy;
      addr_t      nnn;
      logic [8:0] sum;
      r   = '0;
      x   = op[11:8];
      y   = op[7:4];
      n   = op[3:0];
      kk  = op[7:0];
      nnn = op[11:0];
      vx  = vreg[x];
      vy  = vreg[y];
      r.next_pc = pc + 12'd2;
      case (op[15:12])
        GRP_SYS: begin
          if (op == OP_RET) begin
            if (level == 0) begin
              r.stack_fault = 1'b1;
              r.next_pc = pc;
            end else begin
              level--;
              r.next_pc = ret_stack[level];
            end
          end else begin
            r.unhandled = 1'b1;
          end
        end
        GRP_JP: r.next_pc = nnn;
        GRP_CALL: begin
          if (level >= STACK_DEPTH) begin
            r.stack_fault = 1'b1;
            r.next_pc = pc;
          end else begin
            ret_stack[level] = pc + 12'd2;
            level++;
            r.next_pc = nnn;
          end
        end
        GRP_SE: if (vx == kk) r.next_pc = pc + 12'd4;
        GRP_SNE: if (vx != kk) r.next_pc = pc + 12'd4;
        GRP_SER: begin
          if (n != 4'h0) r.unhandled = 1'b1;
          else if (vx == vy) r.next_pc = pc + 12'd4;
        end
        GRP_LD: begin
          r.reg_write = 1'b1;
          r.reg_value = kk;
        end
        GRP_ADD: begin
          r.reg_write = 1'b1;
          r.reg_value = vx + kk;
        end
        GRP_ALU: begin
          r.reg_write = 1'b1;
          case (n)
            ALU_LD: r.reg_value = vy;
            ALU_OR: r.reg_value = vx | vy;
            ALU_AND: r.reg_value = vx & vy;
            ALU_XOR: r.reg_value = vx ^ vy;
            ALU_ADD: begin
              sum = {1'b0, vx} + {1'b0, vy};
              r.flag_write = 1'b1;
              r.flag_value = sum[8];
              r.reg_value = sum[7:0];
            end
            ALU_SUB: begin
              r.flag_write = 1'b1;
              r.flag_value = (vx >= vy);
              r.reg_value = vx - vy;
            end
            ALU_SHR: begin
              r.flag_write = 1'b1;
              r.flag_value = vx[0];
              r.reg_value = vx >> 1;
            end
            ALU_SUBN: begin
              r.flag_write = 1'b1;
              r.flag_value = (vy >= vx);
              r.reg_value = vy - vx;
            end
            ALU_SHL: begin
              r.flag_write = 1'b1;
              r.flag_value = vx[7];
              r.reg_value = vx << 1;
            end
            default: begin
              r.reg_write = 1'b0;
              r.unhandled = 1'b1;
            end
          endcase
        end
        GRP_SNER: begin
          if (n != 4'h0) r.unhandled = 1'b1;
          else if (vx != vy) r.next_pc = pc + 12'd4;
        end
        GRP_LDI: ireg = nnn;
        GRP_JPV0: r.next_pc = addr_t'(vreg[ZERO_REG]) + nnn;
        GRP_RND: begin
          r.reg_write = 1'b1;
          r.reg_value = rnd & kk;
        end
        GRP_KEY: begin
          if (kk == KK_SKP) begin
            if (keys[vx[3:0]]) r.next_pc = pc + 12'd4;
          end else if (kk == KK_SKNP) begin
            if (!keys[vx[3:0]]) r.next_pc = pc + 12'd4;
          end else begin
            r.unhandled = 1'b1;
          end
        end
        default: r.unhandled = 1'b1;
      endcase
      // flag lands first, so Vx = VF ends up holding the result
      if (r.flag_write) vreg[FLAG_REG] = {7'd0, r.flag_value};
      if (r.reg_write) begin
        r.reg_index = x;
        vreg[x] = r.reg_value;
      end
      pc = r.next_pc;
      r.index_value = ireg;
      effects_q.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void compare(logic [OUT_W-1:0] data);
      result_t want;
      if (effects_q.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", data);
        failures++;
        return;
      end
      want = effects_q.pop_front();
      check_field("next_pc", want.next_pc, data[O_NPC +: 12]);
      check_field("reg_write", want.reg_write, data[O_RW]);
      check_field("reg_index", want.reg_index, data[O_RIDX +: 4]);
      check_field("reg_value", want.reg_value, data[O_RVAL +: 8]);
      check_field("flag_write", want.flag_write, data[O_FW]);
      check_field("flag_value", want.flag_value, data[O_FVAL]);
      check_field("index_value", want.index_value, data[O_IDX +: 12]);
      check_field("stack_fault", want.stack_fault, data[O_FAULT]);
      check_field("unhandled", want.unhandled, data[O_UNH]);
    endfunction
  endclass

  localparam logic [15:0] DIRECTED [27] = '{
    OP_RET, 16'h00E0, 16'h60FF, 16'h6101, 16'h8014, 16'h6AFF, 16'h6BFF,
    16'h8AB5, 16'h8AB7, 16'h6F80, 16'h8FFE, 16'h6FFF, 16'h8F06, 16'h7AFF,
    16'h3AFE, 16'h4A00, 16'h5AB0, 16'h9AB1, 16'h8AB8, 16'hAFFF, 16'hC0FF,
    16'hE09E, 16'hE0A1, 16'hE0F5, 16'hBFFF, 16'h1FFE, 16'hD123
  };

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;   // instruction, key_mask, rand_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;        // next_pc .. unhandled, zero pad

  chip8_shadow shadow = new();
  bit          src_quiet = 1'b0;

  chip8_instruction_execute u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // random instruction, biased toward equal compares and sane stack use
  function automatic logic [15:0] pick_instruction();
    logic [3:0] grp;
    ridx_t      x;
    ridx_t      y;
    logic [3:0] n;
    byte_t      kk;
    logic [11:0] nnn;
    int unsigned r;
    grp = 4'($urandom);
    x   = 4'($urandom);
    y   = 4'($urandom);
    n   = 4'($urandom);
    kk  = 8'($urandom);
    nnn = 12'($urandom);
    r   = $urandom_range(0, 7);
    case (grp)
      GRP_SYS: begin
        if (r == 0) return {GRP_SYS, nnn};
        if (r == 1 || shadow.level != 0) return OP_RET;
        return {GRP_SYS, nnn};
      end
      GRP_SE, GRP_SNE: begin
        if (r < 4) kk = shadow.vreg[x];
        return {grp, x, kk};
      end
      GRP_SER, GRP_SNER: begin
        if (r < 3) y = x;
        if (r != 7) n = 4'h0;
        return {grp, x, y, n};
      end
      GRP_ALU: begin
        if (r != 0) begin
          case ($urandom_range(0, 8))
            0: n = ALU_LD;
            1: n = ALU_OR;
            2: n = ALU_AND;
            3: n = ALU_XOR;
            4: n = ALU_ADD;
            5: n = ALU_SUB;
            6: n = ALU_SHR;
            7: n = ALU_SUBN;
            default: n = ALU_SHL;
          endcase
        end
        return {grp, x, y, n};
      end
      GRP_KEY: begin
        if (r < 3) kk = KK_SKP;
        else if (r < 6) kk = KK_SKNP;
        return {grp, x, kk};
      end
      default: return {grp, nnn};
    endcase
  endfunction

  task automatic issue(input logic [15:0] op, input logic [15:0] keys, input byte_t rnd);
    int unsigned gap;
    @(negedge clk_i);
    gap = src_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {rnd, keys, op};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    shadow.retire(op, keys, rnd);
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk_i);
  endtask

  // result side: random backpressure with quiet stretches
  initial begin
    int unsigned stall;
    bit          quiet;
    stall = 0;
    quiet = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 127) == 0) quiet = !quiet;
      if (stall == 0 && !quiet) stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) shadow.compare(m_axis_tdata);
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) issue(DIRECTED[i], 16'($urandom), 8'($urandom));

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 64 == 0) src_quiet = ($urandom_range(0, 3) == 0);
      if (i % 300 == 150) begin
        // idle pipe, then fill past the top of the stack and unwind past empty
        drain();
        repeat (STACK_DEPTH + 1) issue({GRP_CALL, 12'($urandom)}, 16'($urandom), 8'($urandom));
        repeat (STACK_DEPTH + 1) issue(OP_RET, 16'($urandom), 8'($urandom));
      end
      issue(pick_instruction(), 16'($urandom), 8'($urandom));
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (shadow.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
